// File: rtl/time_of_day_clock_24h_macros.svh
// Assertion macros used by the checker file.
`ifndef TIME_OF_DAY_CLOCK_24H_MACROS_SVH
`define TIME_OF_DAY_CLOCK_24H_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define TOD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TOD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tod_pkg.sv
package tod_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_SET      = 3'd0,
    CMD_NEXT_SEC = 3'd1,
    CMD_NEXT_MIN = 3'd2,
    CMD_NEXT_HR  = 3'd3,
    CMD_ADD      = 3'd4,
    CMD_SUB      = 3'd5,
    CMD_QUERY    = 3'd6
  } tod_cmd_e;

  // Day period codes
  typedef enum logic [1:0] {
    PERIOD_MORNING   = 2'd0,
    PERIOD_AFTERNOON = 2'd1,
    PERIOD_EVENING   = 2'd2,
    PERIOD_NIGHT     = 2'd3
  } tod_period_e;

  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinSecMax = 6'd59;
  localparam logic [4:0] DayHours  = 5'd24;
  localparam logic [5:0] BaseSixty = 6'd60;
  localparam logic [4:0] MornStart = 5'd5;
  localparam logic [4:0] NoonStart = 5'd12;
  localparam logic [4:0] EveStart  = 5'd18;
  localparam logic [4:0] NightStart = 5'd20;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [10:0] MinPerHour = 11'd60;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tod_time_t;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] op_hours;
    logic [5:0] op_minutes;
    logic [5:0] op_seconds;
  } tod_in_t;

  typedef struct packed {
    logic [4:0]  cur_hours;
    logic [5:0]  cur_minutes;
    logic [5:0]  cur_seconds;
    logic [16:0] seconds_of_day;
    logic [10:0] minutes_of_day;
    logic [1:0]  day_period;
    logic        is_less;
    logic        is_greater;
    logic        is_equal;
    logic [4:0]  left_hours;
    logic [5:0]  left_minutes;
    logic [5:0]  left_seconds;
  } tod_out_t;

endpackage

// File: rtl/tod_alu.sv
module tod_alu import tod_pkg::*; (
  input  tod_time_t time_i,
  input  tod_in_t   item_i,
  output tod_time_t time_o,
  output tod_out_t  res_o
);

  logic [4:0] op_h;
  logic [5:0] op_m, op_s;
  tod_time_t  nxt_sec, nxt_min, nxt_hr, add_t, sub_t;
  logic [6:0] s_sum, m_sum, s_dif, m_dif;
  logic [5:0] h_sum, h_dif;
  logic       s_c, m_c, s_b, m_b;
  logic [4:0] hr_inc;
  logic       ls_b, lm_b;

  // Operand clamped into range
  always_comb begin
    op_h = (item_i.op_hours   > HourMax)   ? HourMax   : item_i.op_hours;
    op_m = (item_i.op_minutes > MinSecMax) ? MinSecMax : item_i.op_minutes;
    op_s = (item_i.op_seconds > MinSecMax) ? MinSecMax : item_i.op_seconds;
  end

  // Increment paths, each field wraps
  always_comb begin
    hr_inc = (time_i.hours >= HourMax) ? 5'd0 : time_i.hours + 5'd1;

    nxt_hr         = time_i;
    nxt_hr.hours   = hr_inc;

    nxt_min        = time_i;
    if (time_i.minutes >= MinSecMax) begin
      nxt_min.minutes = 6'd0;
      nxt_min.hours   = hr_inc;
    end else begin
      nxt_min.minutes = time_i.minutes + 6'd1;
    end

    nxt_sec = time_i;
    if (time_i.seconds >= MinSecMax) begin
      nxt_sec.seconds = 6'd0;
      if (time_i.minutes >= MinSecMax) begin
        nxt_sec.minutes = 6'd0;
        nxt_sec.hours   = hr_inc;
      end else begin
        nxt_sec.minutes = time_i.minutes + 6'd1;
      end
    end else begin
      nxt_sec.seconds = time_i.seconds + 6'd1;
    end
  end

  // Add with carry, modulo one day
  always_comb begin
    s_sum = {1'b0, time_i.seconds} + {1'b0, op_s};
    s_c   = (s_sum >= {1'b0, BaseSixty});
    add_t.seconds = s_c ? 6'(s_sum - {1'b0, BaseSixty}) : s_sum[5:0];
    m_sum = {1'b0, time_i.minutes} + {1'b0, op_m} + {6'd0, s_c};
    m_c   = (m_sum >= {1'b0, BaseSixty});
    add_t.minutes = m_c ? 6'(m_sum - {1'b0, BaseSixty}) : m_sum[5:0];
    h_sum = {1'b0, time_i.hours} + {1'b0, op_h} + {5'd0, m_c};
    add_t.hours = (h_sum >= {1'b0, DayHours}) ? 5'(h_sum - {1'b0, DayHours}) : h_sum[4:0];
  end

  // Subtract with borrow, modulo one day
  always_comb begin
    s_dif = {1'b0, time_i.seconds} - {1'b0, op_s};
    s_b   = s_dif[6];
    sub_t.seconds = s_b ? 6'(s_dif + {1'b0, BaseSixty}) : s_dif[5:0];
    m_dif = {1'b0, time_i.minutes} - {1'b0, op_m} - {6'd0, s_b};
    m_b   = m_dif[6];
    sub_t.minutes = m_b ? 6'(m_dif + {1'b0, BaseSixty}) : m_dif[5:0];
    h_dif = {1'b0, time_i.hours} - {1'b0, op_h} - {5'd0, m_b};
    sub_t.hours = h_dif[5] ? 5'(h_dif + {1'b0, DayHours}) : h_dif[4:0];
  end

  // Command select
  always_comb begin
    case (tod_cmd_e'(item_i.command))
      CMD_SET:      time_o = '{hours: op_h, minutes: op_m, seconds: op_s};
      CMD_NEXT_SEC: time_o = nxt_sec;
      CMD_NEXT_MIN: time_o = nxt_min;
      CMD_NEXT_HR:  time_o = nxt_hr;
      CMD_ADD:      time_o = add_t;
      CMD_SUB:      time_o = sub_t;
      default:      time_o = time_i;
    endcase
  end

  // Result fields from the new time
  always_comb begin
    res_o.cur_hours      = time_o.hours;
    res_o.cur_minutes    = time_o.minutes;
    res_o.cur_seconds    = time_o.seconds;
    res_o.seconds_of_day = 17'(time_o.hours) * SecPerHour
                         + 17'(time_o.minutes) * 17'(BaseSixty)
                         + 17'(time_o.seconds);
    res_o.minutes_of_day = 11'(time_o.hours) * MinPerHour + 11'(time_o.minutes);

    if (time_o.hours >= MornStart && time_o.hours < NoonStart) begin
      res_o.day_period = PERIOD_MORNING;
    end else if (time_o.hours >= NoonStart && time_o.hours < EveStart) begin
      res_o.day_period = PERIOD_AFTERNOON;
    end else if (time_o.hours >= EveStart && time_o.hours < NightStart) begin
      res_o.day_period = PERIOD_EVENING;
    end else begin
      res_o.day_period = PERIOD_NIGHT;
    end

    // fields are in range, so the packed words compare lexicographically
    res_o.is_equal   = (time_o == {op_h, op_m, op_s});
    res_o.is_less    = (time_o <  {op_h, op_m, op_s});
    res_o.is_greater = (time_o >  {op_h, op_m, op_s});

    // 24:00:00 minus the new time, borrow rippling up
    ls_b = (time_o.seconds != 6'd0);
    res_o.left_seconds = ls_b ? BaseSixty - time_o.seconds : 6'd0;
    lm_b = ls_b || (time_o.minutes != 6'd0);
    res_o.left_minutes = lm_b ? BaseSixty - time_o.minutes - {5'd0, ls_b} : 6'd0;
    res_o.left_hours   = DayHours - time_o.hours - {4'd0, lm_b};
  end

endmodule

// File: rtl/time_of_day_clock_24h.sv
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i/in_stall_o   in_item_i   (tod_in_t)
// out      source     out_valid_o/out_stall_i out_item_o  (tod_out_t)
//
// One item per cycle sustained while the result is not stalled; an accepted
// item goes through the input register, then the command logic into the
// result register.
// Reset clears the time to 00:00:00 and empties both registers.
// A stalled result holds; the input register still takes one more item,
// after which in_stall_o rises until the result is taken.
module time_of_day_clock_24h import tod_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tod_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tod_out_t out_item_o
);

  logic      s1_valid_q, s1_valid_d;
  tod_in_t   s1_item_q;
  logic      out_valid_q, out_valid_d;
  tod_out_t  out_item_q;
  tod_time_t time_q, time_new;
  tod_out_t  res;
  logic      load_out, s1_fire, in_accept;

  // Flow control
  assign load_out   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && load_out;
  assign in_stall_o = s1_valid_q && !load_out;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = load_out ? s1_valid_q : out_valid_q;
  end

  // Command logic
  tod_alu u_alu (
    .time_i (time_q),
    .item_i (s1_item_q),
    .time_o (time_new),
    .res_o  (res)
  );

  // Control and time registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      time_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        time_q <= time_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/tod_checker.sv
`include "time_of_day_clock_24h_macros.svh"

module tod_checker import tod_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input tod_out_t out_item_o
);

  logic [17:0] sod_calc, left_sum;

  assign sod_calc = 18'(out_item_o.cur_hours) * 18'd3600
                  + 18'(out_item_o.cur_minutes) * 18'd60
                  + 18'(out_item_o.cur_seconds);
  assign left_sum = 18'(out_item_o.left_hours) * 18'd3600
                  + 18'(out_item_o.left_minutes) * 18'd60
                  + 18'(out_item_o.left_seconds)
                  + 18'(out_item_o.seconds_of_day);

  // No result straight out of reset
  `TOD_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")
  // Held result stays put
  `TOD_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "stalled item changed")
  // Seconds of day agree with the time fields
  `TOD_ASSERT(a_sod, clk_i, rst_ni, out_valid_o |-> 18'(out_item_o.seconds_of_day) == sod_calc, "seconds of day mismatch")
  // Time left plus time gone is one day
  `TOD_ASSERT(a_left, clk_i, rst_ni, out_valid_o |-> left_sum == 18'd86400, "time left mismatch")
  // Exactly one compare flag
  `TOD_ASSERT(a_cmp, clk_i, rst_ni, out_valid_o |-> $onehot({out_item_o.is_less, out_item_o.is_greater, out_item_o.is_equal}), "compare flags not one-hot")

endmodule

bind time_of_day_clock_24h tod_checker u_tod_checker (.*);

// File: sim/time_of_day_clock_24h_tb.sv
module time_of_day_clock_24h_tb;
  import tod_pkg::*;

  // Command code with no operation of its own; behaves as a query
  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned DaySecs = 86400;
  localparam int unsigned HoldOffAt = 150;
  localparam int unsigned HoldOffCycles = 90;
  localparam int unsigned MaxReports = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b1;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tod_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tod_out_t out_item_o;

  time_of_day_clock_24h dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  tod_in_t     cmd_queue[$];
  tod_out_t    due_results[$];
  int unsigned items_sent = 0;
  int unsigned results_taken = 0;
  int unsigned errors = 0;

  // Predicted time of day
  int unsigned clock_h = 0;
  int unsigned clock_m = 0;
  int unsigned clock_s = 0;

  // Idle gaps drawn at random per item, with runs of back-to-back items
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Applies one command to the predicted time and builds the result it gives
  function automatic tod_out_t advance_clock(tod_in_t cmd);
    int unsigned oh, om, os, now_s, op_s, t, left;
    logic lt, eq;
    tod_out_t r;
    oh = 32'((cmd.op_hours > HourMax) ? HourMax : cmd.op_hours);
    om = 32'((cmd.op_minutes > MinSecMax) ? MinSecMax : cmd.op_minutes);
    os = 32'((cmd.op_seconds > MinSecMax) ? MinSecMax : cmd.op_seconds);
    now_s = clock_h * 3600 + clock_m * 60 + clock_s;
    op_s = oh * 3600 + om * 60 + os;
    t = now_s;
    case (cmd.command)
      CMD_SET:      t = op_s;
      CMD_NEXT_SEC: t = (now_s + 1) % DaySecs;
      CMD_ADD:      t = (now_s + op_s) % DaySecs;
      CMD_SUB:      t = (now_s + DaySecs - op_s) % DaySecs;
      default:      t = now_s;
    endcase
    clock_h = t / 3600;
    clock_m = (t / 60) % 60;
    clock_s = t % 60;
    // minute and hour steps leave the lower fields alone
    if (cmd.command == CMD_NEXT_MIN) begin
      if (clock_m >= 59) begin
        clock_m = 0;
        clock_h = (clock_h >= 23) ? 0 : clock_h + 1;
      end else begin
        clock_m++;
      end
    end else if (cmd.command == CMD_NEXT_HR) begin
      clock_h = (clock_h >= 23) ? 0 : clock_h + 1;
    end

    if (clock_h != oh) lt = clock_h < oh;
    else if (clock_m != om) lt = clock_m < om;
    else lt = clock_s < os;
    eq = (clock_h == oh) && (clock_m == om) && (clock_s == os);

    t = clock_h * 3600 + clock_m * 60 + clock_s;
    left = DaySecs - t;
    r.cur_hours = 5'(clock_h);
    r.cur_minutes = 6'(clock_m);
    r.cur_seconds = 6'(clock_s);
    r.seconds_of_day = 17'(t);
    r.minutes_of_day = 11'(clock_h * 60 + clock_m);
    if (clock_h >= 32'(MornStart) && clock_h < 32'(NoonStart))
      r.day_period = PERIOD_MORNING;
    else if (clock_h >= 32'(NoonStart) && clock_h < 32'(EveStart))
      r.day_period = PERIOD_AFTERNOON;
    else if (clock_h >= 32'(EveStart) && clock_h < 32'(NightStart))
      r.day_period = PERIOD_EVENING;
    else r.day_period = PERIOD_NIGHT;
    r.is_less = lt;
    r.is_greater = !lt && !eq;
    r.is_equal = eq;
    r.left_hours = 5'(left / 3600);
    r.left_minutes = 6'((left / 60) % 60);
    r.left_seconds = 6'(left % 60);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReports)
        $display("result %0d: %s expected %0d, got %0d", results_taken, name, want, got);
    end
  endfunction

  // Sender: one item from the queue at a time, held while stalled
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(advance_clock(in_item_i));
        items_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled: item and valid stay as they are
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_item_i <= cmd_queue.pop_front();
        in_valid_i <= 1'b1;
        send_gap = draw_wait(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result, then stalls for a drawn number of cycles
  int unsigned stall_left = 0;
  int unsigned recv_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    tod_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_taken++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("result %0d: none expected, got %h", results_taken, out_item_o);
        end else begin
          want = due_results.pop_front();
          check_field("cur_hours", 32'(want.cur_hours), 32'(out_item_o.cur_hours));
          check_field("cur_minutes", 32'(want.cur_minutes), 32'(out_item_o.cur_minutes));
          check_field("cur_seconds", 32'(want.cur_seconds), 32'(out_item_o.cur_seconds));
          check_field("seconds_of_day", 32'(want.seconds_of_day),
                      32'(out_item_o.seconds_of_day));
          check_field("minutes_of_day", 32'(want.minutes_of_day),
                      32'(out_item_o.minutes_of_day));
          check_field("day_period", 32'(want.day_period), 32'(out_item_o.day_period));
          check_field("is_less", 32'(want.is_less), 32'(out_item_o.is_less));
          check_field("is_greater", 32'(want.is_greater), 32'(out_item_o.is_greater));
          check_field("is_equal", 32'(want.is_equal), 32'(out_item_o.is_equal));
          check_field("left_hours", 32'(want.left_hours), 32'(out_item_o.left_hours));
          check_field("left_minutes", 32'(want.left_minutes), 32'(out_item_o.left_minutes));
          check_field("left_seconds", 32'(want.left_seconds), 32'(out_item_o.left_seconds));
        end
        stall_left = draw_wait(recv_calm);
        // one long hold-off so the block fills and stalls its input
        if (results_taken == HoldOffAt) stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_cmd(logic [2:0] command, int unsigned h, int unsigned m, int unsigned s);
    tod_in_t it;
    it.command = command;
    it.op_hours = 5'(h);
    it.op_minutes = 6'(m);
    it.op_seconds = 6'(s);
    cmd_queue.push_back(it);
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned n_items;
    int unsigned sel;
    tod_in_t it;

    // reset edge at time zero so every reset branch sees it
    rst_ni <= 1'b0;

    // directed: reset time, wraps, period edges, clamping, compares
    push_cmd(CMD_QUERY, 0, 0, 0);
    push_cmd(CMD_SET, 31, 63, 63);
    push_cmd(CMD_NEXT_SEC, 23, 59, 59);
    push_cmd(CMD_SET, 23, 59, 30);
    push_cmd(CMD_NEXT_MIN, 0, 0, 30);
    push_cmd(CMD_SET, 23, 10, 5);
    push_cmd(CMD_NEXT_HR, 0, 10, 5);
    push_cmd(CMD_SET, 4, 59, 59);
    push_cmd(CMD_NEXT_SEC, 5, 0, 0);
    push_cmd(CMD_SET, 11, 59, 59);
    push_cmd(CMD_NEXT_SEC, 12, 0, 0);
    push_cmd(CMD_SET, 17, 59, 59);
    push_cmd(CMD_NEXT_SEC, 18, 0, 0);
    push_cmd(CMD_SET, 19, 59, 59);
    push_cmd(CMD_NEXT_SEC, 20, 0, 0);
    push_cmd(CMD_ADD, 23, 59, 59);
    push_cmd(CMD_SUB, 23, 59, 59);
    push_cmd(CMD_ADD, 31, 63, 63);
    push_cmd(CMD_SUB, 0, 0, 0);
    push_cmd(CMD_SET, 12, 30, 30);
    push_cmd(CmdUnused, 12, 30, 30);
    push_cmd(CMD_QUERY, 12, 30, 31);
    push_cmd(CMD_QUERY, 12, 31, 0);
    push_cmd(CMD_QUERY, 11, 59, 59);
    push_cmd(CMD_NEXT_MIN, 24, 60, 60);

    // random: mostly in-range operands, some near carry edges, some raw bits
    for (int i = 0; i < 400; i++) begin
      sel = $urandom_range(0, 99);
      it.command = 3'($urandom_range(0, 7));
      if (sel < 12) begin
        it.op_hours = 5'($urandom_range(0, 31));
        it.op_minutes = 6'($urandom_range(0, 63));
        it.op_seconds = 6'($urandom_range(0, 63));
      end else if (sel < 35) begin
        it.op_hours = 5'(($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 23));
        it.op_minutes = 6'($urandom_range(57, 59));
        it.op_seconds = 6'($urandom_range(57, 59));
      end else begin
        it.op_hours = 5'($urandom_range(0, 23));
        it.op_minutes = 6'($urandom_range(0, 59));
        it.op_seconds = 6'($urandom_range(0, 59));
      end
      cmd_queue.push_back(it);
    end
    n_items = cmd_queue.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_sent == n_items && due_results.size() == 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
